### rtl/core/eqlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqlb_pkg: shared types and constants of the quote line blanker
// Character widths, register indexes and the result record.
// ----------------------------------------------------------------------------
package eqlb_pkg;

  localparam int unsigned CharW    = 21;
  localparam int unsigned TdataW   = 24;
  localparam int unsigned MarginW  = 4;
  localparam int unsigned QcountW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumQuote = 4;
  localparam int unsigned LevelW   = 2;

  localparam logic [CharW-1:0] SpaceCode   = 21'd32;
  localparam logic [CharW-1:0] NewlineCode = 21'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MARGIN      = 3'd0,
    CFG_QUOTE_COUNT = 3'd1,
    CFG_QUOTE_A     = 3'd2,
    CFG_QUOTE_B     = 3'd3,
    CFG_QUOTE_C     = 3'd4,
    CFG_QUOTE_D     = 3'd5
  } cfg_idx_e;

  // one result as it travels to the output buffer
  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             blanked;
    logic             last_of_run;
  } res_t;

  // output buffer status seen by the sequencer
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              pop;
  } ob_status_t;

endpackage

### rtl/core/eqlb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqlb_store: pending character memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module eqlb_store #(
  parameter int unsigned DEPTH = 15,
  parameter int unsigned AW    = 4
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [eqlb_pkg::CharW-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [eqlb_pkg::CharW-1:0]  rdata_o
);

  logic [eqlb_pkg::CharW-1:0] mem [DEPTH];
  logic [eqlb_pkg::CharW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/eqlb_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqlb_outbuf: two-entry result buffer
// Decouples the result stage from output backpressure.
// ----------------------------------------------------------------------------
module eqlb_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  eqlb_pkg::res_t       push_res_i,
  output eqlb_pkg::ob_status_t status_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output eqlb_pkg::res_t       m_res_o
);

  eqlb_pkg::res_t                 ent_q [2];
  logic                           wptr_q, rptr_q;
  logic [eqlb_pkg::LevelW-1:0]    level_q, level_d;
  logic                           pop;

  assign m_valid_o = (level_q != '0);
  assign pop       = m_valid_o & m_ready_i;
  assign m_res_o   = ent_q[rptr_q];

  always_comb begin
    level_d = level_q;
    if (push_i && !pop) begin
      level_d = level_q + 2'd1;
    end else if (!push_i && pop) begin
      level_d = level_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      level_q <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop)    rptr_q <= ~rptr_q;
      level_q <= level_d;
    end
  end

  assign status_o.level = level_q;
  assign status_o.pop   = pop;

endmodule

### rtl/core/eqlb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqlb_ctrl: line state, configuration and flush sequencer
// Decides per character whether to hold, release or pass it, and walks
// the pending memory when held characters are released.
// ----------------------------------------------------------------------------
module eqlb_ctrl #(
  parameter int unsigned MAX_MARGIN = 15,
  parameter int unsigned AW         = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  input  logic [eqlb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [eqlb_pkg::CharW-1:0]    cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [eqlb_pkg::CharW-1:0]    in_char_i,
  input  logic                          in_eot_i,
  // pending memory
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [eqlb_pkg::CharW-1:0]    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [eqlb_pkg::CharW-1:0]    mem_rdata_i,
  // output buffer
  input  eqlb_pkg::ob_status_t          ob_status_i,
  output logic                          push_o,
  output eqlb_pkg::res_t                push_res_o
);

  localparam int unsigned LW = $clog2(MAX_MARGIN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TAIL
  } state_e;

  // configuration registers
  logic [eqlb_pkg::MarginW-1:0] margin_q;
  logic [eqlb_pkg::QcountW-1:0] qcount_q;
  logic [eqlb_pkg::CharW-1:0]   quote_q [eqlb_pkg::NumQuote];

  // line state
  logic                         ls_q, ls_d;
  logic                         quoting_q, quoting_d;
  logic [eqlb_pkg::MarginW-1:0] col_q, col_d;
  logic [LW-1:0]                len_q, len_d;

  // sequencer
  state_e                       state_q, state_d;
  logic [LW-1:0]                fidx_q, fidx_d;
  logic [LW-1:0]                flen_q, flen_d;
  logic                         fblank_q, fblank_d;
  logic [eqlb_pkg::CharW-1:0]   tail_char_q, tail_char_d;
  logic                         tail_blank_q, tail_blank_d;

  // result stage in front of the memory read data
  logic                         s1_valid_q, s1_valid_d;
  logic                         s1_mem_q, s1_mem_d;
  eqlb_pkg::res_t               s1_res_q, s1_res_d;

  logic [eqlb_pkg::LevelW-1:0]  occ;
  logic                         credit_ok;
  logic                         acc;
  logic [eqlb_pkg::NumQuote-1:0] qmatch;
  logic                         is_q, is_nl, quoting_n, can_hold, hold, tb;
  logic [eqlb_pkg::MarginW-1:0] eff_margin;

  // room for one more result once the stage ahead has drained into the buffer
  assign occ       = ob_status_i.level + eqlb_pkg::LevelW'(s1_valid_q);
  assign credit_ok = (occ < 2'd2) || ((occ == 2'd2) && ob_status_i.pop);

  assign in_ready_o = (state_q == ST_IDLE) && credit_ok;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    for (int i = 0; i < eqlb_pkg::NumQuote; i++) begin
      qmatch[i] = (qcount_q > eqlb_pkg::QcountW'(i)) && (quote_q[i] == in_char_i);
    end
  end

  always_comb begin
    if (MAX_MARGIN < 15 && 8'(margin_q) > 8'(MAX_MARGIN)) begin
      eff_margin = eqlb_pkg::MarginW'(MAX_MARGIN);
    end else begin
      eff_margin = margin_q;
    end
  end

  assign is_q      = |qmatch;
  assign is_nl     = (in_char_i == eqlb_pkg::NewlineCode);
  assign quoting_n = quoting_q | (ls_q & is_q);
  assign can_hold  = (col_q < eff_margin) && (len_q < LW'(MAX_MARGIN));
  assign hold      = !is_nl && !quoting_n && ls_q && can_hold && !in_eot_i;
  assign tb        = quoting_n && !is_nl;

  assign mem_we_o    = acc && hold;
  assign mem_waddr_o = len_q[AW-1:0];
  assign mem_wdata_o = in_char_i;
  assign mem_re_o    = (state_q == ST_FLUSH) && credit_ok;
  assign mem_raddr_o = fidx_q[AW-1:0];

  always_comb begin
    ls_d         = ls_q;
    quoting_d    = quoting_q;
    col_d        = col_q;
    len_d        = len_q;
    state_d      = state_q;
    fidx_d       = fidx_q;
    flen_d       = flen_q;
    fblank_d     = fblank_q;
    tail_char_d  = tail_char_q;
    tail_blank_d = tail_blank_q;
    s1_valid_d   = 1'b0;
    s1_mem_d     = s1_mem_q;
    s1_res_d     = s1_res_q;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_eot_i || is_nl) begin
            ls_d      = 1'b1;
            quoting_d = 1'b0;
            col_d     = '0;
            len_d     = '0;
          end else if (quoting_n) begin
            quoting_d = 1'b1;
            len_d     = '0;
            if (col_q < eff_margin) begin
              col_d = col_q + 4'd1;
            end else begin
              ls_d = 1'b0;
            end
          end else if (ls_q) begin
            if (can_hold) begin
              len_d = len_q + LW'(1);
              col_d = col_q + 4'd1;
            end else begin
              ls_d  = 1'b0;
              len_d = '0;
            end
          end

          if (!hold) begin
            if (len_q != '0) begin
              state_d      = ST_FLUSH;
              fidx_d       = '0;
              flen_d       = len_q;
              fblank_d     = quoting_n;
              tail_char_d  = in_char_i;
              tail_blank_d = tb;
            end else begin
              s1_valid_d           = 1'b1;
              s1_mem_d             = 1'b0;
              s1_res_d.out_char    = tb ? eqlb_pkg::SpaceCode : in_char_i;
              s1_res_d.blanked     = tb;
              s1_res_d.last_of_run = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (credit_ok) begin
          s1_valid_d           = 1'b1;
          s1_mem_d             = 1'b1;
          s1_res_d.out_char    = eqlb_pkg::SpaceCode;
          s1_res_d.blanked     = fblank_q;
          s1_res_d.last_of_run = 1'b0;
          fidx_d               = fidx_q + LW'(1);
          if (LW'(fidx_q + LW'(1)) == flen_q) begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (credit_ok) begin
          s1_valid_d           = 1'b1;
          s1_mem_d             = 1'b0;
          s1_res_d.out_char    = tail_blank_q ? eqlb_pkg::SpaceCode : tail_char_q;
          s1_res_d.blanked     = tail_blank_q;
          s1_res_d.last_of_run = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a character read back from memory becomes a space when the run is blanked
  always_comb begin
    push_res_o = s1_res_q;
    if (s1_mem_q && !s1_res_q.blanked) begin
      push_res_o.out_char = mem_rdata_i;
    end
  end
  assign push_o = s1_valid_q;

  always_ff @(posedge clk_i) begin
    fidx_q       <= fidx_d;
    flen_q       <= flen_d;
    fblank_q     <= fblank_d;
    tail_char_q  <= tail_char_d;
    tail_blank_q <= tail_blank_d;
    s1_mem_q     <= s1_mem_d;
    s1_res_q     <= s1_res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s1_valid_q <= 1'b0;
      ls_q       <= 1'b1;
      quoting_q  <= 1'b0;
      col_q      <= '0;
      len_q      <= '0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= s1_valid_d;
      ls_q       <= ls_d;
      quoting_q  <= quoting_d;
      col_q      <= col_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q   <= 4'd10;
      qcount_q   <= 3'd2;
      quote_q[0] <= 21'd62;
      quote_q[1] <= 21'd124;
      quote_q[2] <= '0;
      quote_q[3] <= '0;
    end else if (cfg_valid_i) begin
      case (eqlb_pkg::cfg_idx_e'(cfg_index_i))
        eqlb_pkg::CFG_MARGIN:      margin_q   <= cfg_data_i[eqlb_pkg::MarginW-1:0];
        eqlb_pkg::CFG_QUOTE_COUNT: qcount_q   <= cfg_data_i[eqlb_pkg::QcountW-1:0];
        eqlb_pkg::CFG_QUOTE_A:     quote_q[0] <= cfg_data_i;
        eqlb_pkg::CFG_QUOTE_B:     quote_q[1] <= cfg_data_i;
        eqlb_pkg::CFG_QUOTE_C:     quote_q[2] <= cfg_data_i;
        eqlb_pkg::CFG_QUOTE_D:     quote_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/email_quote_line_blanker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// email_quote_line_blanker_top: blanks email-quoted lines in a text stream
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata in_char, tuser end_of_text
//   m_axis    out  m_axis_tvalid/tready      tdata out_char, tuser blanked,
//                                            tlast last_of_run
//   cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A character that releases held characters is accepted, then the pending
// memory is read once per held character, then the final character is sent;
// input waits until that is done. A passed character goes through the result
// stage and the output buffer before it leaves; released characters follow,
// one per cycle while the result stage and output buffer have room.
// Reset is asynchronous and needs no clearing pass; the memory is only read
// below its fill count. A stalled output stops input once two results wait
// in the result stage and the two-entry output buffer.
// ----------------------------------------------------------------------------
module email_quote_line_blanker_top #(
  parameter int unsigned MAX_MARGIN = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [eqlb_pkg::TdataW-1:0]         s_axis_tdata_i,   // [20:0] in_char
  input  logic [0:0]                          s_axis_tuser_i,   // [0] end_of_text
  // output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [eqlb_pkg::TdataW-1:0]         m_axis_tdata_o,   // [20:0] out_char
  output logic [0:0]                          m_axis_tuser_o,   // [0] blanked
  output logic                                m_axis_tlast_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [eqlb_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [eqlb_pkg::CharW-1:0]          cfg_data_i
);

  localparam int unsigned AW = (MAX_MARGIN > 1) ? $clog2(MAX_MARGIN) : 1;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [eqlb_pkg::CharW-1:0]   mem_wdata, mem_rdata;
  eqlb_pkg::ob_status_t         ob_status;
  logic                         push;
  eqlb_pkg::res_t               push_res, m_res;

  assign cfg_ready_o = 1'b1;

  eqlb_ctrl #(
    .MAX_MARGIN (MAX_MARGIN),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_char_i   (s_axis_tdata_i[eqlb_pkg::CharW-1:0]),
    .in_eot_i    (s_axis_tuser_i[0]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .ob_status_i (ob_status),
    .push_o      (push),
    .push_res_o  (push_res)
  );

  eqlb_store #(
    .DEPTH (MAX_MARGIN),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  eqlb_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_res_i (push_res),
    .status_o   (ob_status),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_res_o    (m_res)
  );

  assign m_axis_tdata_o = {{(eqlb_pkg::TdataW - eqlb_pkg::CharW){1'b0}}, m_res.out_char};
  assign m_axis_tuser_o = m_res.blanked;
  assign m_axis_tlast_o = m_res.last_of_run;

endmodule

### tb/tb_email_quote_line_blanker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_email_quote_line_blanker_top: self-checking bench of the quote line blanker
// A stimulus table of short edge-case texts, then random lines under several
// register settings. Each accepted character runs through a line-state
// predictor; every output transfer is compared with the oldest expected
// character. Both stream sides insert random wait cycles per item, except in phases that turn gaps off.
// ----------------------------------------------------------------------------
module tb_email_quote_line_blanker_top;

  localparam int unsigned MaxHold    = 15;
  localparam int          SettleCyc  = 40;
  localparam int          StallLimit = 2000;
  localparam int          RandItems  = 260;

  localparam logic [eqlb_pkg::CharW-1:0] ChGt     = 21'd62;   // '>'
  localparam logic [eqlb_pkg::CharW-1:0] ChBar    = 21'd124;  // '|'
  localparam logic [eqlb_pkg::CharW-1:0] ChLowA   = 21'd97;   // 'a'
  localparam logic [eqlb_pkg::CharW-1:0] ChUpperA = 21'd65;   // 'A'
  localparam logic [eqlb_pkg::CharW-1:0] ChX      = 21'd120;  // 'x'
  localparam logic [eqlb_pkg::CharW-1:0] ChY      = 21'd121;  // 'y'
  localparam logic [eqlb_pkg::CharW-1:0] ChZ      = 21'd122;  // 'z'
  localparam logic [eqlb_pkg::CharW-1:0] ChK      = 21'd107;  // 'k'
  localparam logic [eqlb_pkg::CharW-1:0] ChTop    = 21'h10FFFF;

  typedef struct {
    logic [eqlb_pkg::CharW-1:0] ch;
    logic                       eot;
    bit                         typed;
    eqlb_pkg::res_t             want;
  } char_item_t;

  typedef struct {
    bit                         is_reg;
    eqlb_pkg::cfg_idx_e         idx;
    logic [eqlb_pkg::CharW-1:0] val;
    logic                       eot;
    bit                         typed;
    logic [eqlb_pkg::CharW-1:0] want_ch;
    logic                       want_bl;
  } stim_row_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [eqlb_pkg::TdataW-1:0]   s_axis_tdata_i  = '0;
  logic [0:0]                    s_axis_tuser_i  = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [eqlb_pkg::TdataW-1:0]   m_axis_tdata_o;
  logic [0:0]                    m_axis_tuser_o;
  logic                          m_axis_tlast_o;
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic [eqlb_pkg::CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [eqlb_pkg::CharW-1:0]    cfg_data_i      = '0;

  // register shadow and line state of the predictor
  logic [eqlb_pkg::MarginW-1:0]  cfg_margin;
  logic [eqlb_pkg::QcountW-1:0]  cfg_qcount;
  logic [eqlb_pkg::CharW-1:0]    cfg_quote [eqlb_pkg::NumQuote];
  bit                            ln_at_start;
  bit                            ln_quoting;
  int                            ln_column;
  logic [eqlb_pkg::CharW-1:0]    held_chars [MaxHold];
  int                            held_len;

  eqlb_pkg::res_t                step_res [$];
  eqlb_pkg::res_t                expected_chars_q [$];
  char_item_t                    sent_chars_q [$];
  stim_row_t                     stim_rows [$];

  int                            errors       = 0;
  int                            random_items = 0;
  int                            idle_cycles  = 0;
  bit                            no_gaps      = 1'b0;
  bit                            cfg_busy     = 1'b0;
  char_item_t                    acc_item;
  eqlb_pkg::res_t                got_res;
  eqlb_pkg::res_t                want_res;

  email_quote_line_blanker_top #(
    .MAX_MARGIN(MaxHold)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_line();
    ln_at_start = 1'b1;
    ln_quoting  = 1'b0;
    ln_column   = 0;
    held_len    = 0;
  endfunction

  function automatic void emit_char(input logic [eqlb_pkg::CharW-1:0] ch, input bit blank);
    eqlb_pkg::res_t r;
    r.out_char    = blank ? eqlb_pkg::SpaceCode : ch;
    r.blanked     = blank;
    r.last_of_run = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void release_held(input bit blank);
    int i;
    for (i = 0; i < held_len; i++) emit_char(held_chars[i], blank);
    held_len = 0;
  endfunction

  function automatic void apply_reg(input logic [eqlb_pkg::CfgIdxW-1:0] idx,
                                    input logic [eqlb_pkg::CharW-1:0] val);
    case (eqlb_pkg::cfg_idx_e'(idx))
      eqlb_pkg::CFG_MARGIN:      cfg_margin   = val[eqlb_pkg::MarginW-1:0];
      eqlb_pkg::CFG_QUOTE_COUNT: cfg_qcount   = val[eqlb_pkg::QcountW-1:0];
      eqlb_pkg::CFG_QUOTE_A:     cfg_quote[0] = val;
      eqlb_pkg::CFG_QUOTE_B:     cfg_quote[1] = val;
      eqlb_pkg::CFG_QUOTE_C:     cfg_quote[2] = val;
      eqlb_pkg::CFG_QUOTE_D:     cfg_quote[3] = val;
      default: ;
    endcase
  endfunction

  function automatic void blank_predict(input logic [eqlb_pkg::CharW-1:0] ch,
                                        input logic eot);
    int   eff_margin;
    int   qn;
    int   i;
    bit   hit;
    step_res.delete();
    eff_margin = (cfg_margin > MaxHold) ? MaxHold : cfg_margin;
    qn = (cfg_qcount > eqlb_pkg::NumQuote) ? eqlb_pkg::NumQuote : cfg_qcount;
    hit = 1'b0;
    for (i = 0; i < qn; i++) if (cfg_quote[i] == ch) hit = 1'b1;
    if (ln_at_start && hit) ln_quoting = 1'b1;

    if (ch == eqlb_pkg::NewlineCode) begin
      release_held(ln_quoting);
      emit_char(ch, 1'b0);
      ln_at_start = 1'b1;
      ln_quoting  = 1'b0;
      ln_column   = 0;
    end else if (ln_quoting) begin
      release_held(1'b1);
      emit_char(ch, 1'b1);
      if (ln_column < eff_margin) ln_column++;
      else ln_at_start = 1'b0;
    end else if (ln_at_start) begin
      if (ln_column < eff_margin && held_len < MaxHold) begin
        held_chars[held_len] = ch;
        held_len++;
        ln_column++;
      end else begin
        // window closed or store full: everything goes out unchanged
        ln_at_start = 1'b0;
        release_held(1'b0);
        emit_char(ch, 1'b0);
      end
    end else begin
      emit_char(ch, 1'b0);
    end

    if (eot) begin
      release_held(1'b0);
      clear_line();
    end

    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  // ------------------------------------------------------ monitor and checker

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_margin   = 4'd10;
      cfg_qcount   = 3'd2;
      cfg_quote[0] = ChGt;
      cfg_quote[1] = ChBar;
      cfg_quote[2] = '0;
      cfg_quote[3] = '0;
      clear_line();
    end else begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);

      if (s_axis_tvalid_i && s_axis_tready_o) begin
        acc_item = sent_chars_q.pop_front();
        blank_predict(s_axis_tdata_i[eqlb_pkg::CharW-1:0], s_axis_tuser_i[0]);
        if (acc_item.typed) begin
          expected_chars_q.insert(expected_chars_q.size(), acc_item.want);
        end else begin
          foreach (step_res[k]) expected_chars_q.insert(expected_chars_q.size(), step_res[k]);
        end
      end

      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_res.out_char    = m_axis_tdata_o[eqlb_pkg::CharW-1:0];
        got_res.blanked     = m_axis_tuser_o[0];
        got_res.last_of_run = m_axis_tlast_o;
        if (expected_chars_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output transfer, expected none, got char %h",
                   $time, got_res.out_char);
        end else begin
          want_res = expected_chars_q.pop_front();
          if (got_res.out_char !== want_res.out_char) begin
            errors++;
            $display("%0t: out_char expected %h got %h",
                     $time, want_res.out_char, got_res.out_char);
          end
          if (got_res.blanked !== want_res.blanked) begin
            errors++;
            $display("%0t: blanked expected %b got %b",
                     $time, want_res.blanked, got_res.blanked);
          end
          if (got_res.last_of_run !== want_res.last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %b got %b",
                     $time, want_res.last_of_run, got_res.last_of_run);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("email_quote_line_blanker_top test failed");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic send_char(input logic [eqlb_pkg::CharW-1:0] ch, input logic eot,
                           input bit typed, input eqlb_pkg::res_t want);
    int         gap;
    char_item_t it;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.ch    = ch;
    it.eot   = eot;
    it.typed = typed;
    it.want  = want;
    sent_chars_q.insert(sent_chars_q.size(), it);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(eqlb_pkg::TdataW-eqlb_pkg::CharW){1'b0}}, ch};
    s_axis_tuser_i  <= eot;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input eqlb_pkg::cfg_idx_e idx,
                           input logic [eqlb_pkg::CharW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  // block idle: all results out, and time for a held character to settle
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_chars_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  initial begin : drain
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid_o);
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void put_row(input bit is_reg, input eqlb_pkg::cfg_idx_e idx,
                                  input logic [eqlb_pkg::CharW-1:0] val, input logic eot,
                                  input bit typed,
                                  input logic [eqlb_pkg::CharW-1:0] want_ch,
                                  input logic want_bl);
    stim_row_t r;
    r.is_reg  = is_reg;
    r.idx     = idx;
    r.val     = val;
    r.eot     = eot;
    r.typed   = typed;
    r.want_ch = want_ch;
    r.want_bl = want_bl;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic void put_chr(input logic [eqlb_pkg::CharW-1:0] ch, input logic eot);
    put_row(1'b0, eqlb_pkg::CFG_MARGIN, ch, eot, 1'b0, '0, 1'b0);
  endfunction

  function automatic void put_typ(input logic [eqlb_pkg::CharW-1:0] ch, input logic eot,
                                  input logic [eqlb_pkg::CharW-1:0] want_ch,
                                  input logic want_bl);
    put_row(1'b0, eqlb_pkg::CFG_MARGIN, ch, eot, 1'b1, want_ch, want_bl);
  endfunction

  function automatic void put_reg(input eqlb_pkg::cfg_idx_e idx,
                                  input logic [eqlb_pkg::CharW-1:0] val);
    put_row(1'b1, idx, val, 1'b0, 1'b0, '0, 1'b0);
  endfunction

  function automatic logic [eqlb_pkg::CharW-1:0] filler_char();
    case ($urandom_range(0, 19))
      0:       return eqlb_pkg::CharW'($urandom_range(0, ChTop));
      1:       return eqlb_pkg::NewlineCode;
      2:       return eqlb_pkg::SpaceCode;
      default: return eqlb_pkg::CharW'($urandom_range(33, 126));
    endcase
  endfunction

  function automatic logic [eqlb_pkg::CharW-1:0] pick_quote();
    case ($urandom_range(0, 5))
      0:       return ChGt;
      1:       return ChBar;
      2:       return eqlb_pkg::NewlineCode;
      3:       return ChTop;
      4:       return eqlb_pkg::CharW'($urandom_range(0, ChTop));
      default: return eqlb_pkg::CharW'($urandom_range(33, 126));
    endcase
  endfunction

  task automatic write_phase_regs();
    logic [eqlb_pkg::CharW-1:0] r;
    r = eqlb_pkg::CharW'($urandom_range(0, 21'h1FFFFF));
    case ($urandom_range(0, 3))
      0:       r[eqlb_pkg::MarginW-1:0] = '0;
      1:       r[eqlb_pkg::MarginW-1:0] = '1;
      default: ;
    endcase
    write_reg(eqlb_pkg::CFG_MARGIN, r);
    write_reg(eqlb_pkg::CFG_QUOTE_COUNT, eqlb_pkg::CharW'($urandom_range(0, 21'h1FFFFF)));
    write_reg(eqlb_pkg::CFG_QUOTE_A, pick_quote());
    write_reg(eqlb_pkg::CFG_QUOTE_B, pick_quote());
    write_reg(eqlb_pkg::CFG_QUOTE_C, pick_quote());
    write_reg(eqlb_pkg::CFG_QUOTE_D, pick_quote());
    cfg_valid_i <= 1'b0;
  endtask

  // one text line, often with a quote character somewhere near its start
  task automatic send_line();
    int                         len;
    int                         qpos;
    int                         i;
    bit                         quoted;
    logic [eqlb_pkg::CharW-1:0] ch;
    len    = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 12);
    quoted = ($urandom_range(0, 1) == 1);
    qpos   = $urandom_range(0, cfg_margin + 2);
    for (i = 0; i < len; i++) begin
      if (quoted && i == qpos) ch = cfg_quote[$urandom_range(0, eqlb_pkg::NumQuote-1)];
      else ch = filler_char();
      send_char(ch, ($urandom_range(0, 39) == 0), 1'b0, '0);
    end
    if ($urandom_range(0, 5) == 0) send_char(filler_char(), 1'b1, 1'b0, '0);
    else send_char(eqlb_pkg::NewlineCode, ($urandom_range(0, 9) == 0), 1'b0, '0);
    random_items += len + 1;
  endtask

  initial begin : main
    eqlb_pkg::res_t want;
    int             i;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: margin 10, quotes '>' and '|'
    put_typ(eqlb_pkg::NewlineCode, 1'b0, eqlb_pkg::NewlineCode, 1'b0);
    put_typ(ChGt,                  1'b0, eqlb_pkg::SpaceCode,   1'b1);
    put_typ(ChLowA,                1'b0, eqlb_pkg::SpaceCode,   1'b1);
    put_typ(eqlb_pkg::NewlineCode, 1'b0, eqlb_pkg::NewlineCode, 1'b0);
    put_chr(eqlb_pkg::SpaceCode, 1'b0);
    put_chr(ChX, 1'b0);
    put_chr(ChBar, 1'b0);             // releases the held pair as spaces
    put_chr(eqlb_pkg::NewlineCode, 1'b0);
    put_typ(ChTop, 1'b1, ChTop, 1'b0); // not held: it ends the text and passes unchanged
    // widest window, count above four, newline as a quote character
    put_reg(eqlb_pkg::CFG_MARGIN, 21'd15);
    put_reg(eqlb_pkg::CFG_QUOTE_COUNT, 21'd7);
    put_reg(eqlb_pkg::CFG_QUOTE_C, ChTop);
    put_reg(eqlb_pkg::CFG_QUOTE_D, eqlb_pkg::NewlineCode);
    put_chr(ChLowA, 1'b0);
    put_chr(eqlb_pkg::NewlineCode, 1'b0);
    // pending store runs full, last one also ends the text
    for (i = 0; i < 16; i++) put_chr(eqlb_pkg::CharW'(ChUpperA + i), (i == 15));
    // window shrinks while characters are held
    put_chr(ChX, 1'b0);
    put_chr(ChY, 1'b0);
    put_reg(eqlb_pkg::CFG_MARGIN, 21'd1);
    put_chr(ChZ, 1'b0);
    put_chr(eqlb_pkg::NewlineCode, 1'b0);
    put_reg(eqlb_pkg::CFG_MARGIN, 21'd0);
    put_reg(eqlb_pkg::CFG_QUOTE_COUNT, 21'd0);
    put_typ(ChGt, 1'b0, ChGt, 1'b0);
    put_typ(ChK,  1'b1, ChK,  1'b0);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].is_reg) begin
        if (!cfg_busy) begin
          quiesce();
          cfg_busy = 1'b1;
        end
        write_reg(stim_rows[r].idx, stim_rows[r].val);
      end else begin
        if (cfg_busy) begin
          cfg_valid_i <= 1'b0;
          cfg_busy = 1'b0;
        end
        want.out_char    = stim_rows[r].want_ch;
        want.blanked     = stim_rows[r].want_bl;
        want.last_of_run = 1'b1;
        send_char(stim_rows[r].val, stim_rows[r].eot, stim_rows[r].typed, want);
      end
    end

    while (random_items < RandItems) begin
      quiesce();
      no_gaps = ($urandom_range(0, 3) == 0);
      write_phase_regs();
      repeat ($urandom_range(3, 8)) send_line();
    end

    quiesce();
    if (errors == 0 && expected_chars_q.size() == 0) begin
      $display("email_quote_line_blanker_top test passed");
    end else begin
      $display("email_quote_line_blanker_top test failed");
    end
    $finish;
  end

endmodule

### email_quote_line_blanker_top.f
rtl/core/eqlb_pkg.sv
rtl/core/eqlb_store.sv
rtl/core/eqlb_outbuf.sv
rtl/core/eqlb_ctrl.sv
rtl/core/email_quote_line_blanker_top.sv
tb/tb_email_quote_line_blanker_top.sv
